### design/assert_macros.svh
// Assertion helpers, clocked on clk; ASSERT_RUN is disabled during the active-low async reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RUN(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RUN(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### design/c8core_pkg.sv
`timescale 1ns / 1ps
package c8core_pkg;
	localparam int MemBytes = 4096;
	localparam int AddrW = 12;
	localparam int ScreenCols = 64;
	localparam int ScreenRows = 32;
	localparam logic [AddrW-1:0] ResetPc = 12'h200;
	localparam logic [AddrW-1:0] FontBase = 12'h050;
	localparam logic [AddrW-1:0] FontEnd = 12'h0A0;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_STEP = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_FAULT = 2'd1;
	localparam logic [1:0] STAT_HALTED = 2'd2;

	localparam logic [3:0] NIB_SYS = 4'h0;
	localparam logic [3:0] NIB_JMP = 4'h1;
	localparam logic [3:0] NIB_LD = 4'h6;
	localparam logic [3:0] NIB_ADD = 4'h7;
	localparam logic [3:0] NIB_LDI = 4'hA;
	localparam logic [3:0] NIB_DRW = 4'hD;
	localparam logic [11:0] SYS_CLS = 12'h0E0;

	typedef logic [3:0] op_t;
	localparam op_t OP_NOP = 4'd0;
	localparam op_t OP_CLR_WR = 4'd1;
	localparam op_t OP_ACCEPT = 4'd2;
	localparam op_t OP_CAP_HI = 4'd3;
	localparam op_t OP_CAP_LO = 4'd4;
	localparam op_t OP_EXEC = 4'd5;
	localparam op_t OP_DRAW_Y = 4'd6;
	localparam op_t OP_SPR_RD = 4'd7;
	localparam op_t OP_SPR_WR = 4'd8;
	localparam op_t OP_PUBLISH = 4'd9;

	typedef struct packed {
		op_t op;
		logic [AddrW-1:0] sweep;
		logic [3:0] row;
	} cmd_t;

	typedef struct packed {
		logic halted;
		logic pc_end;
		logic is_draw;
		logic [3:0] nrows;
		logic out_busy;
	} stat_t;

	localparam logic [7:0] GLYPHS [80] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	function automatic logic [7:0] reset_byte(input logic [AddrW-1:0] a);
		logic [AddrW-1:0] off;
		off = a - FontBase;
		if (a >= FontBase && a < FontEnd) return GLYPHS[off[6:0]];
		return 8'h00;
	endfunction
endpackage

### design/chip8_instruction_core_subset_core.sv
`timescale 1ns / 1ps
// Partial CHIP-8 core: memory loads, single instruction steps, display row reads.
// Input channel: in_valid/in_stall carry kind, address, data; a transaction is
// taken when in_valid is high and in_stall low. Output channel: out_valid/
// out_stall carry status, pc, opcode, flag_value, display_row, screen_changed,
// one result per input transaction, in order.
// Config: cfg_we with cfg_wdata sets the program counter and clears the halt.
// From accept to out_valid, a load, read or halted/fault step goes only through
// the done state; a non-draw instruction first makes two serial reads of the single
// program memory port and an execute step; a draw of N rows adds a Y step and per
// sprite byte a memory read followed by a row update. One item at a time: the next
// transaction is taken only after the result is registered.
// Reset: program memory is swept over all 4096 bytes (font at 0x50, rest zero)
// while in_stall is held high; registers, screen and halt clear at once, pc is
// 0x200. A stalled result holds in the output register; the core finishes the
// next item up to its result and then waits for the register to drain.
module chip8_instruction_core_subset_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] kind,
	input logic [11:0] address,
	input logic [7:0] data,
	input logic cfg_we,
	input logic [11:0] cfg_wdata,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic [11:0] pc,
	output logic [15:0] opcode,
	output logic [7:0] flag_value,
	output logic [63:0] display_row,
	output logic screen_changed
);
	import c8core_pkg::*;

	cmd_t cmd;
	stat_t stat;

	c8core_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .stat(stat), .cmd(cmd)
	);

	c8core_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.kind(kind), .address(address), .data(data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .pc(pc), .opcode(opcode), .flag_value(flag_value),
		.display_row(display_row), .screen_changed(screen_changed)
	);
endmodule

### design/c8core_ram.sv
`timescale 1ns / 1ps
module c8core_ram #(
	parameter int Width = 8,
	parameter int Depth = 4096
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

### design/c8core_dp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module c8core_dp (
	input logic clk,
	input logic arst_n,
	input c8core_pkg::cmd_t cmd,
	output c8core_pkg::stat_t stat,
	input logic [1:0] kind,
	input logic [11:0] address,
	input logic [7:0] data,
	input logic cfg_we,
	input logic [11:0] cfg_wdata,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic [11:0] pc,
	output logic [15:0] opcode,
	output logic [7:0] flag_value,
	output logic [63:0] display_row,
	output logic screen_changed
);
	import c8core_pkg::*;

	logic [AddrW-1:0] pc_q, idx_q;
	logic [7:0] vreg_q [16];
	logic [ScreenCols-1:0] fb_q [ScreenRows];
	logic halted_q;
	logic [7:0] hi_q, px_q, py_q;
	logic [15:0] opc_q;
	logic [1:0] res_status_q;
	logic [63:0] res_row_q;
	logic res_changed_q;

	logic ram_we;
	logic [AddrW-1:0] ram_waddr, ram_raddr;
	logic [7:0] ram_wdata, ram_rdata;
	logic [3:0] rd_idx;
	logic [7:0] vrd;
	logic [8:0] row9;
	logic [63:0] mask, cur_row;

	assign stat.halted = halted_q;
	assign stat.pc_end = &pc_q[AddrW-1:1];
	assign stat.is_draw = opc_q[15:12] == NIB_DRW;
	assign stat.nrows = opc_q[3:0];
	assign stat.out_busy = out_valid && out_stall;

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = address;
		ram_wdata = data;
		ram_raddr = pc_q;
		if (cmd.op == OP_CLR_WR) begin
			ram_we = 1'b1;
			ram_waddr = cmd.sweep;
			ram_wdata = reset_byte(cmd.sweep);
		end else if (cmd.op == OP_ACCEPT && kind == KIND_LOAD) begin
			ram_we = 1'b1;
		end
		if (cmd.op == OP_CAP_HI) ram_raddr = pc_q + 12'd1;
		else if (cmd.op == OP_SPR_RD) ram_raddr = idx_q + {8'd0, cmd.row};
	end

	c8core_ram #(.Width(8), .Depth(MemBytes)) u_mem (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	assign rd_idx = (cmd.op == OP_EXEC) ? opc_q[11:8] : opc_q[7:4];
	assign vrd = vreg_q[rd_idx];
	assign row9 = {1'b0, py_q} + {5'd0, cmd.row};
	// sprite byte placed at column px; columns past 63 fall off the right
	assign mask = (px_q[7:6] == 2'b00) ? ({ram_rdata, 56'd0} >> px_q[5:0]) : 64'd0;
	assign cur_row = fb_q[row9[4:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ResetPc;
			idx_q <= '0;
			halted_q <= 1'b0;
			for (int i = 0; i < 16; i++) vreg_q[i] <= '0;
			for (int i = 0; i < ScreenRows; i++) fb_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				pc_q <= cfg_wdata;
				halted_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_ACCEPT: begin
					if (kind == KIND_STEP && !halted_q && stat.pc_end) halted_q <= 1'b1;
				end
				OP_CAP_LO: pc_q <= pc_q + 12'd2;
				OP_EXEC: begin
					unique case (opc_q[15:12])
						NIB_SYS: if (opc_q[11:0] == SYS_CLS)
							for (int i = 0; i < ScreenRows; i++) fb_q[i] <= '0;
						NIB_JMP: pc_q <= opc_q[11:0];
						NIB_LD: vreg_q[opc_q[11:8]] <= opc_q[7:0];
						NIB_ADD: vreg_q[opc_q[11:8]] <= vreg_q[opc_q[11:8]] + opc_q[7:0];
						NIB_LDI: idx_q <= opc_q[11:0];
						default: ;
					endcase
				end
				OP_DRAW_Y: vreg_q[15] <= 8'd0;
				OP_SPR_WR: begin
					if (row9 < 9'(ScreenRows)) begin
						if (|(cur_row & mask)) vreg_q[15] <= 8'd1;
						fb_q[row9[4:0]] <= cur_row ^ mask;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers of the current transaction
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_ACCEPT: begin
				res_status_q <= (kind == KIND_STEP && !halted_q && stat.pc_end) ? STAT_FAULT
					: (halted_q ? STAT_HALTED : STAT_OK);
				opc_q <= '0;
				res_changed_q <= 1'b0;
				res_row_q <= (kind == KIND_READ && address < 12'(ScreenRows))
					? fb_q[address[4:0]] : 64'd0;
			end
			OP_CAP_HI: hi_q <= ram_rdata;
			OP_CAP_LO: opc_q <= {hi_q, ram_rdata};
			OP_EXEC: begin
				if (opc_q[15:12] == NIB_DRW) begin
					px_q <= vrd;
					res_changed_q <= 1'b1;
				end
				if (opc_q[15:12] == NIB_SYS && opc_q[11:0] == SYS_CLS) res_changed_q <= 1'b1;
			end
			OP_DRAW_Y: py_q <= vrd;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.op == OP_PUBLISH) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_PUBLISH) begin
			status <= res_status_q;
			pc <= pc_q;
			opcode <= opc_q;
			flag_value <= vreg_q[15];
			display_row <= res_row_q;
			screen_changed <= res_changed_q;
		end
	end

	`ASSERT_RUN(a_pub_free, cmd.op == OP_PUBLISH |-> !(out_valid && out_stall))
	`ASSERT_RUN(a_fault_halts, (cmd.op == OP_ACCEPT && kind == KIND_STEP && !halted_q
		&& stat.pc_end && !cfg_we) |=> halted_q)
	`ASSERT_RUN(a_pc_step, cmd.op == OP_CAP_LO |=> pc_q == $past(pc_q) + 12'd2)
endmodule

### design/c8core_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module c8core_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] kind,
	input c8core_pkg::stat_t stat,
	output c8core_pkg::cmd_t cmd
);
	import c8core_pkg::*;

	localparam logic [3:0] ST_CLR = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_F_HI = 4'd2;
	localparam logic [3:0] ST_F_LO = 4'd3;
	localparam logic [3:0] ST_EXEC = 4'd4;
	localparam logic [3:0] ST_DY = 4'd5;
	localparam logic [3:0] ST_SRD = 4'd6;
	localparam logic [3:0] ST_SWR = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0] state_q, state_d;
	logic [AddrW-1:0] sweep_q;
	logic [3:0] row_q;
	logic accept, last_row;

	assign in_stall = state_q != ST_IDLE;
	assign accept = in_valid && !in_stall;
	assign last_row = ({1'b0, row_q} + 5'd1) == {1'b0, stat.nrows};

	always_comb begin
		state_d = state_q;
		cmd.op = OP_NOP;
		cmd.sweep = sweep_q;
		cmd.row = row_q;
		unique case (state_q)
			ST_CLR: begin
				cmd.op = OP_CLR_WR;
				if (&sweep_q) state_d = ST_IDLE;
			end
			ST_IDLE: if (accept) begin
				cmd.op = OP_ACCEPT;
				state_d = (kind == KIND_STEP && !stat.halted && !stat.pc_end)
					? ST_F_HI : ST_DONE;
			end
			ST_F_HI: begin cmd.op = OP_CAP_HI; state_d = ST_F_LO; end
			ST_F_LO: begin cmd.op = OP_CAP_LO; state_d = ST_EXEC; end
			ST_EXEC: begin
				cmd.op = OP_EXEC;
				state_d = stat.is_draw ? ST_DY : ST_DONE;
			end
			ST_DY: begin
				cmd.op = OP_DRAW_Y;
				state_d = (stat.nrows == 4'd0) ? ST_DONE : ST_SRD;
			end
			ST_SRD: begin cmd.op = OP_SPR_RD; state_d = ST_SWR; end
			ST_SWR: begin
				cmd.op = OP_SPR_WR;
				state_d = last_row ? ST_DONE : ST_SRD;
			end
			ST_DONE: if (!stat.out_busy) begin
				cmd.op = OP_PUBLISH;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			sweep_q <= '0;
			row_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLR) sweep_q <= sweep_q + 12'd1;
			if (state_q == ST_DY) row_q <= '0;
			else if (state_q == ST_SWR) row_q <= row_q + 4'd1;
		end
	end

	`ASSERT_RUN(a_lo_after_hi, state_q == ST_F_LO |-> $past(state_q) == ST_F_HI)
	`ASSERT_RUN(a_row_range, state_q == ST_SWR |-> row_q < stat.nrows)
	`ASSERT_RUN(a_no_accept_busy, state_q == ST_CLR |-> in_stall)
endmodule
